// ===== src/pva_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pva_pkg: shared types and constants of the voice allocator
// widths, event and action codes, the per-voice entry and the scan summary
// ----------------------------------------------------------------------------
package pva_pkg;

    localparam int VOICES  = 8;
    localparam int VIDX_W  = $clog2(VOICES);
    localparam int RANK_W  = $clog2(VOICES);
    localparam int CNT_W   = $clog2(VOICES + 1);
    localparam int NOTE_W  = 7;
    localparam int OP_W    = 2;
    localparam int VOICE_W = 3;
    localparam int ACT_W   = 2;

    // event codes
    localparam logic [OP_W-1:0] OP_NOTE_ON  = 2'd0;
    localparam logic [OP_W-1:0] OP_NOTE_OFF = 2'd1;
    localparam logic [OP_W-1:0] OP_DONE     = 2'd2;

    // action codes
    localparam logic [ACT_W-1:0] ACT_NONE    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_START   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd2;
    localparam logic [ACT_W-1:0] ACT_FREED   = 2'd3;

    // one voice slot as it travels around the ring
    typedef struct packed {
        logic              valid;
        logic [NOTE_W-1:0] note;
        logic [RANK_W-1:0] rank;
    } entry_t;

    // what one trip around the ring found
    typedef struct packed {
        logic              hit;
        logic [VIDX_W-1:0] hit_idx;
        logic [RANK_W-1:0] hit_rank;
        logic              empty;
        logic [VIDX_W-1:0] empty_idx;
        logic [VIDX_W-1:0] zero_idx;
        logic [CNT_W-1:0]  count;
        logic              dv_valid;
        logic [NOTE_W-1:0] dv_note;
        logic [RANK_W-1:0] dv_rank;
    } scan_t;

endpackage
`default_nettype wire

// ===== src/pva_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pva_in_if: event channel
// valid/ready channel carrying one midi or envelope event per beat
// ----------------------------------------------------------------------------
interface pva_in_if import pva_pkg::*;;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [NOTE_W-1:0] note;
    logic [2:0]        done_voice;

    modport source (output valid, output op, output note, output done_voice, input ready);
    modport sink   (input valid, input op, input note, input done_voice, output ready);
endinterface
`default_nettype wire

// ===== src/pva_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pva_out_if: result channel
// valid/ready channel carrying one voice action per beat
// ----------------------------------------------------------------------------
interface pva_out_if import pva_pkg::*;;
    logic               valid;
    logic               ready;
    logic [VOICE_W-1:0] voice;
    logic [ACT_W-1:0]   action;
    logic [NOTE_W-1:0]  played_note;
    logic               stolen;
    logic               retriggered;

    modport source (output valid, output voice, output action, output played_note,
                    output stolen, output retriggered, input ready);
    modport sink   (input valid, input voice, input action, input played_note,
                    input stolen, input retriggered, output ready);
endinterface
`default_nettype wire

// ===== src/polyphonic_voice_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// polyphonic_voice_allocator: note to voice assignment with oldest stealing
// eight voices in a shifting ring of cells, one result beat per event beat
// ----------------------------------------------------------------------------
// Each event beat (note on, note off, envelope done) yields exactly one result
// beat naming the voice acted upon. The voice slots sit in a ring of cells that
// rotates one place per cycle during a trip; an event makes two full trips
// around it, a lookup trip that finds the holder of the note, the first empty
// voice, the oldest voice and the pool count, then an update trip that writes
// the chosen slot and closes up the age ranks. An event therefore passes from
// accept through the lookup trip, the update trip and a finish state before
// the next accept; the result beat sits in an output register, and a new event
// waits only while the previous result has not been taken when the update trip
// ends. The ring is empty after reset with no clearing pass.
// ----------------------------------------------------------------------------
module polyphonic_voice_allocator import pva_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    pva_in_if.sink    req,
    pva_out_if.source rsp
);

    // sequencer states
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_UPDATE = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [VIDX_W-1:0] idx_reg;
    logic [VIDX_W-1:0] idx_next;

    // captured event
    logic [OP_W-1:0]   op_reg;
    logic [NOTE_W-1:0] note_reg;
    logic [2:0]        dv_reg;

    // result register
    logic               out_valid_reg;
    logic [VOICE_W-1:0] voice_reg;
    logic [ACT_W-1:0]   action_reg;
    logic [NOTE_W-1:0]  pnote_reg;
    logic               stolen_reg;
    logic               retrig_reg;

    logic   accept;
    logic   shift;
    logic   last_step;
    logic   load_out;
    entry_t tail;
    entry_t feed;
    scan_t  scan;

    // decision taken from the lookup trip
    logic              wr_en;
    logic              wr_valid;
    logic [VIDX_W-1:0] tgt;
    logic              close_en;
    logic [RANK_W-1:0] close_rank;
    logic [RANK_W-1:0] new_rank;
    logic [ACT_W-1:0]  res_action;
    logic [NOTE_W-1:0] res_note;
    logic              res_stolen;
    logic              res_retrig;

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign shift     = (state_reg == ST_SCAN) || (state_reg == ST_UPDATE);
    assign last_step = (idx_reg == '0);
    assign load_out  = (state_reg == ST_FINISH) && (!out_valid_reg || rsp.ready);

    // ring of voice cells
    pva_ring u_ring
    (
        .clk   (clk),
        .rst_n (rst_n),
        .shift (shift),
        .feed  (feed),
        .tail  (tail)
    );

    // lookup trip bookkeeping
    pva_scan u_scan
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (accept),
        .step       (state_reg == ST_SCAN),
        .idx        (idx_reg),
        .tail       (tail),
        .note       (note_reg),
        .done_voice (dv_reg),
        .scan       (scan)
    );

    // pick target voice and rank changes once the lookup trip is done
    always_comb
    begin
        wr_en      = 1'b0;
        wr_valid   = 1'b0;
        tgt        = '0;
        close_en   = 1'b0;
        close_rank = '0;
        new_rank   = '0;
        res_action = ACT_NONE;
        res_note   = '0;
        res_stolen = 1'b0;
        res_retrig = 1'b0;
        unique case (op_reg)
            OP_NOTE_ON:
            begin
                wr_en      = 1'b1;
                wr_valid   = 1'b1;
                res_action = ACT_START;
                res_note   = note_reg;
                priority if (scan.hit)
                begin
                    // retrigger: drop own rank, become newest of the rest
                    tgt        = scan.hit_idx;
                    close_en   = 1'b1;
                    close_rank = scan.hit_rank;
                    new_rank   = scan.count[RANK_W-1:0] - RANK_W'(1);
                    res_retrig = 1'b1;
                end
                else if (scan.empty)
                begin
                    tgt      = scan.empty_idx;
                    new_rank = scan.count[RANK_W-1:0];
                end
                else
                begin
                    // pool full: steal the oldest voice
                    tgt        = scan.zero_idx;
                    close_en   = 1'b1;
                    close_rank = '0;
                    new_rank   = RANK_W'(VOICES - 1);
                    res_stolen = 1'b1;
                end
            end
            OP_NOTE_OFF:
            begin
                if (scan.hit)
                begin
                    tgt        = scan.hit_idx;
                    res_action = ACT_RELEASE;
                    res_note   = note_reg;
                end
            end
            OP_DONE:
            begin
                if (scan.dv_valid)
                begin
                    wr_en      = 1'b1;
                    tgt        = VIDX_W'(dv_reg);
                    close_en   = 1'b1;
                    close_rank = scan.dv_rank;
                    res_action = ACT_FREED;
                    res_note   = scan.dv_note;
                end
            end
            default:
            begin
                res_action = ACT_NONE;
            end
        endcase
    end

    // feed back into the ring: untouched on the lookup trip, edited on the update trip
    always_comb
    begin
        feed = tail;
        if (state_reg == ST_UPDATE)
        begin
            if (wr_en && idx_reg == tgt)
            begin
                feed = '{valid: wr_valid, note: note_reg, rank: new_rank};
            end
            else if (close_en && tail.valid && tail.rank > close_rank)
            begin
                feed.rank = tail.rank - RANK_W'(1);
            end
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SCAN;
                    idx_next   = VIDX_W'(VOICES - 1);
                end
            end
            ST_SCAN:
            begin
                idx_next = idx_reg - VIDX_W'(1);
                if (last_step)
                begin
                    state_next = ST_UPDATE;
                    idx_next   = VIDX_W'(VOICES - 1);
                end
            end
            ST_UPDATE:
            begin
                idx_next = idx_reg - VIDX_W'(1);
                if (last_step)
                begin
                    state_next = ST_FINISH;
                    idx_next   = '0;
                end
            end
            ST_FINISH:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    // event capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= req.op;
            note_reg <= req.note;
            dv_reg   <= req.done_voice;
        end
    end

    // result beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            voice_reg  <= (res_action == ACT_NONE) ? '0 : VOICE_W'(tgt);
            action_reg <= res_action;
            pnote_reg  <= res_note;
            stolen_reg <= res_stolen;
            retrig_reg <= res_retrig;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.voice       = voice_reg;
    assign rsp.action      = action_reg;
    assign rsp.played_note = pnote_reg;
    assign rsp.stolen      = stolen_reg;
    assign rsp.retriggered = retrig_reg;

    // an accepted event always starts a lookup trip
    a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_SCAN)
        else $error("accepted event did not start a lookup trip");

    // stealing only happens with every voice held
    a_steal_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && res_stolen) |-> scan.count == CNT_W'(VOICES))
        else $error("voice stolen while the pool was not full");

    // a result is never both stolen and retriggered
    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(stolen_reg && retrig_reg))
        else $error("result marked both stolen and retriggered");

    // the update trip ends with the ring back in place, ready for the result
    a_trip_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPDATE && last_step) |=> state_reg == ST_FINISH)
        else $error("update trip did not end in finish");

endmodule
`default_nettype wire

// ===== src/pva_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pva_cell: one voice slot of the ring
// holds a voice entry and passes it on when the ring shifts
// ----------------------------------------------------------------------------
module pva_cell import pva_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   shift,
    input  wire entry_t d,
    output entry_t      q
);

    logic              valid_reg;
    logic [NOTE_W-1:0] note_reg;
    logic [RANK_W-1:0] rank_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (shift)
        begin
            valid_reg <= d.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            note_reg <= d.note;
            rank_reg <= d.rank;
        end
    end

    assign q = '{valid: valid_reg, note: note_reg, rank: rank_reg};

endmodule
`default_nettype wire

// ===== src/pva_ring.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pva_ring: chain of voice cells
// cell 0 takes the feed, each cell hands its entry to the next, last is tail
// ----------------------------------------------------------------------------
module pva_ring import pva_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   shift,
    input  wire entry_t feed,
    output entry_t      tail
);

    entry_t q [VOICES];

    for (genvar i = 0; i < VOICES; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            pva_cell u_cell (.clk(clk), .rst_n(rst_n), .shift(shift), .d(feed), .q(q[i]));
        end
        else
        begin : g_body
            pva_cell u_cell (.clk(clk), .rst_n(rst_n), .shift(shift), .d(q[i-1]), .q(q[i]));
        end
    end

    assign tail = q[VOICES-1];

endmodule
`default_nettype wire

// ===== src/pva_scan.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pva_scan: ring observer
// collects holder, empty slot, oldest voice and pool count as entries pass
// ----------------------------------------------------------------------------
module pva_scan import pva_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              step,
    input  wire logic [VIDX_W-1:0] idx,
    input  wire entry_t            tail,
    input  wire logic [NOTE_W-1:0] note,
    input  wire logic [2:0]        done_voice,
    output scan_t                  scan
);

    scan_t scan_reg;
    scan_t scan_next;

    // voices pass from high index to low, so the last match is the lowest index
    always_comb
    begin
        scan_next = scan_reg;
        if (start)
        begin
            scan_next = '0;
        end
        else if (step)
        begin
            if (tail.valid && tail.note == note)
            begin
                scan_next.hit      = 1'b1;
                scan_next.hit_idx  = idx;
                scan_next.hit_rank = tail.rank;
            end
            if (!tail.valid)
            begin
                scan_next.empty     = 1'b1;
                scan_next.empty_idx = idx;
            end
            if (tail.valid && tail.rank == '0)
            begin
                scan_next.zero_idx = idx;
            end
            if (tail.valid)
            begin
                scan_next.count = scan_reg.count + CNT_W'(1);
            end
            if (idx == VIDX_W'(done_voice))
            begin
                scan_next.dv_valid = tail.valid;
                scan_next.dv_note  = tail.note;
                scan_next.dv_rank  = tail.rank;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg <= '0;
        end
        else
        begin
            scan_reg <= scan_next;
        end
    end

    assign scan = scan_reg;

endmodule
`default_nettype wire
